// ----- hdl/midi_byte_stream_parser_defines.svh -----
// Assertion macros for the MIDI byte stream parser.
`ifndef MIDI_BYTE_STREAM_PARSER_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is high.
`define MBP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Clocked check that also runs during reset.
`define MBP_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MBP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MBP_ASSERT_RST(lbl, clk_s, prop, msg)
`endif

`endif

// ----- hdl/mbp_pkg.sv -----
// Types and constants shared by the MIDI byte stream parser modules.
`timescale 1ns / 1ps

package mbp_pkg;

  // Decoded event kinds.
  typedef enum logic [3:0] {
    KIND_NOTE_ON     = 4'd0,
    KIND_NOTE_OFF    = 4'd1,
    KIND_CC          = 4'd2,
    KIND_PITCH       = 4'd3,
    KIND_PROGRAM     = 4'd4,
    KIND_CHAN_AT     = 4'd5,
    KIND_POLY_AT     = 4'd6,
    KIND_REALTIME    = 4'd7,
    KIND_MTC         = 4'd8,
    KIND_SONG_POS    = 4'd9,
    KIND_SONG_SEL    = 4'd10,
    KIND_TUNE        = 4'd11,
    KIND_SYSEX_START = 4'd12,
    KIND_SYSEX_DATA  = 4'd13,
    KIND_SYSEX_STOP  = 4'd14
  } event_kind_t;

  // System status bytes.
  localparam logic [7:0] ST_NONE        = 8'h00;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_MTC         = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_TUNE        = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_RT_MIN      = 8'hF8;
  localparam logic [7:0] ST_SYS_RESET   = 8'hFF;

  // Upper nibbles of channel voice status bytes.
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_POLY_AT  = 4'hA;
  localparam logic [3:0] HI_CC       = 4'hB;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_CHAN_AT  = 4'hD;
  localparam logic [3:0] HI_PITCH    = 4'hE;

  // Parser state carried between bytes.
  typedef struct packed {
    logic [7:0] running_status;
    logic       awaiting_second_data;
    logic [6:0] held_first_data;
    logic       inside_sysex;
  } parser_state_t;

  // One decoded event.
  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [13:0] song_pointer;
    logic [7:0]  realtime_code;
  } midi_event_t;

endpackage

// ----- hdl/mbp_in_reg.sv -----
// Input register that holds one received byte until the decoder takes it.
`timescale 1ns / 1ps

module mbp_in_reg
  import mbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  // Stall the sender while a held byte cannot move on.
  assign byte_stall = hold_valid && !advance;

  // Load a new request whenever the held one leaves or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      hold_byte <= rx_byte;
    end
  end

endmodule

// ----- hdl/mbp_decode.sv -----
// Byte decoder: next parser state and the optional event for one byte.
`timescale 1ns / 1ps

module mbp_decode
  import mbp_pkg::*;
(
  input  logic [7:0]    in_byte,
  input  parser_state_t st,
  output parser_state_t st_next,
  output logic          has_event,
  output midi_event_t   ev
);

  logic [3:0] hi;
  logic [3:0] ch;
  logic [6:0] data;

  assign hi   = st.running_status[7:4];
  assign ch   = st.running_status[3:0];
  assign data = in_byte[6:0];

  always_comb begin
    st_next          = st;
    has_event        = 1'b0;
    ev.kind          = KIND_NOTE_ON;
    ev.channel       = '0;
    ev.first_data    = '0;
    ev.second_data   = '0;
    ev.song_pointer  = '0;
    ev.realtime_code = '0;

    if (in_byte[7]) begin
      if (in_byte >= ST_RT_MIN) begin
        // Real-time byte: pass through, system reset drops running status
        if (in_byte == ST_SYS_RESET) begin
          st_next.running_status = ST_NONE;
        end
        has_event        = 1'b1;
        ev.kind          = KIND_REALTIME;
        ev.realtime_code = in_byte;
      end else begin
        // Any other status ends sysex and drops a pending data byte
        st_next.inside_sysex         = 1'b0;
        st_next.awaiting_second_data = 1'b0;
        if (in_byte < ST_SYSEX_START) begin
          st_next.running_status = in_byte;
        end else begin
          st_next.running_status = ST_NONE;
          case (in_byte)
            ST_TUNE: begin
              has_event = 1'b1;
              ev.kind   = KIND_TUNE;
            end
            ST_SYSEX_START: begin
              st_next.inside_sysex = 1'b1;
              has_event            = 1'b1;
              ev.kind              = KIND_SYSEX_START;
            end
            ST_SYSEX_END: begin
              has_event = 1'b1;
              ev.kind   = KIND_SYSEX_STOP;
            end
            ST_MTC, ST_SONG_POS, ST_SONG_SEL: begin
              st_next.running_status = in_byte;
            end
            default: begin
            end
          endcase
        end
      end
    end else if (st.inside_sysex) begin
      // Sysex payload byte
      has_event     = 1'b1;
      ev.kind       = KIND_SYSEX_DATA;
      ev.first_data = data;
    end else if (st.awaiting_second_data) begin
      // Second data byte completes a three-byte message
      st_next.awaiting_second_data = 1'b0;
      ev.first_data                = st.held_first_data;
      ev.second_data               = data;
      if (st.running_status == ST_SONG_POS) begin
        st_next.running_status = ST_NONE;
        has_event              = 1'b1;
        ev.kind                = KIND_SONG_POS;
        ev.song_pointer        = {data, st.held_first_data};
      end else begin
        ev.channel = ch;
        case (hi)
          HI_NOTE_ON: begin
            has_event = 1'b1;
            ev.kind   = (data == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
          end
          HI_NOTE_OFF: begin
            has_event = 1'b1;
            ev.kind   = KIND_NOTE_OFF;
          end
          HI_PITCH: begin
            has_event = 1'b1;
            ev.kind   = KIND_PITCH;
          end
          HI_POLY_AT: begin
            has_event = 1'b1;
            ev.kind   = KIND_POLY_AT;
          end
          HI_CC: begin
            has_event = 1'b1;
            ev.kind   = KIND_CC;
          end
          default: begin
          end
        endcase
      end
    end else if (st.running_status == ST_NONE) begin
      // Data with no running status: drop
    end else if (st.running_status == ST_MTC) begin
      st_next.running_status = ST_NONE;
      has_event              = 1'b1;
      ev.kind                = KIND_MTC;
      ev.first_data          = data;
    end else if (st.running_status == ST_SONG_SEL) begin
      st_next.running_status = ST_NONE;
      has_event              = 1'b1;
      ev.kind                = KIND_SONG_SEL;
      ev.first_data          = data;
    end else if (hi < HI_PROGRAM || hi == HI_PITCH ||
                 st.running_status == ST_SONG_POS) begin
      // First of two data bytes: hold it
      st_next.held_first_data      = data;
      st_next.awaiting_second_data = 1'b1;
    end else begin
      // Two-byte channel messages
      ev.channel    = ch;
      ev.first_data = data;
      case (hi)
        HI_PROGRAM: begin
          has_event = 1'b1;
          ev.kind   = KIND_PROGRAM;
        end
        HI_CHAN_AT: begin
          has_event = 1'b1;
          ev.kind   = KIND_CHAN_AT;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/mbp_out_reg.sv -----
// Result register that holds one decoded event until the receiver takes it.
`timescale 1ns / 1ps

module mbp_out_reg
  import mbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  midi_event_t load_event,
  input  logic        event_stall,
  output logic        event_valid,
  output logic        free,
  output midi_event_t held_event
);

  // Room for a new event when empty or when the current one is taken now.
  assign free = !event_valid || !event_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_event <= load_event;
    end
  end

endmodule

// ----- hdl/midi_byte_stream_parser.sv -----
// MIDI 1.0 byte stream parser with running status, top level.
// Path: input register, combinational decoder, result register that drives the outputs.
// Throughput: one byte per cycle unless stalled; a byte with no event never waits on the
// result register. The only stall source is a held event the receiver has not yet taken.
// Reset: synchronous, clears running status, pending data, sysex flag and both valid bits.
`timescale 1ns / 1ps
`include "midi_byte_stream_parser_defines.svh"

module midi_byte_stream_parser
  import mbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [3:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  first_data,
  output logic [6:0]  second_data,
  output logic [13:0] song_pointer,
  output logic [7:0]  realtime_code
);

  parser_state_t state;
  parser_state_t state_next;
  logic          hold_valid;
  logic [7:0]    hold_byte;
  logic          has_event;
  midi_event_t   dec_event;
  midi_event_t   held_event;
  logic          out_free;
  logic          advance;
  logic          step;

  // Move the held byte on when it makes no event or the result register has room.
  assign advance = !has_event || out_free;
  assign step    = hold_valid && advance;

  mbp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  mbp_decode u_decode (
    .in_byte   (hold_byte),
    .st        (state),
    .st_next   (state_next),
    .has_event (has_event),
    .ev        (dec_event)
  );

  mbp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (step && has_event),
    .load_event  (dec_event),
    .event_stall (event_stall),
    .event_valid (event_valid),
    .free        (out_free),
    .held_event  (held_event)
  );

  // Advance parser state once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Drive the result fields.
  assign event_kind    = held_event.kind;
  assign channel       = held_event.channel;
  assign first_data    = held_event.first_data;
  assign second_data   = held_event.second_data;
  assign song_pointer  = held_event.song_pointer;
  assign realtime_code = held_event.realtime_code;

  `MBP_ASSERT(a_sysex_excl_pending, clk, rst, state.inside_sysex |-> (!state.awaiting_second_data && state.running_status == ST_NONE), "sysex active with running status or pending data")
  `MBP_ASSERT(a_channel_voice_only, clk, rst, (event_valid && event_kind > KIND_POLY_AT) |-> channel == 4'd0, "channel set on a non-voice event")
  `MBP_ASSERT(a_songpos_only, clk, rst, (event_valid && event_kind != KIND_SONG_POS) |-> song_pointer == 14'd0, "song pointer set on a non-songpos event")
  `MBP_ASSERT(a_realtime_code, clk, rst, (event_valid && realtime_code != 8'd0) |-> (event_kind == KIND_REALTIME && realtime_code[7:3] == 5'b11111), "realtime code on wrong event")
  `MBP_ASSERT_RST(a_reset_clears, clk, rst |=> (!event_valid && !state.inside_sysex && !hold_valid), "reset left state active")

endmodule

// ----- dv/tb_midi_byte_stream_parser.sv -----
// Self-checking testbench for the MIDI byte stream parser with running status.
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser;
  import mbp_pkg::*;

  // Status bytes with no name in the package, and the largest data byte.
  localparam logic [7:0] ST_UNDEF_F4     = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5     = 8'hF5;
  localparam logic [7:0] ST_ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] DATA_MAX        = 8'h7F;

  localparam int RANDOM_ITEMS = 700;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  rx_byte;
  logic        event_valid;
  logic        event_stall;
  logic [3:0]  event_kind;
  logic [3:0]  channel;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [13:0] song_pointer;
  logic [7:0]  realtime_code;

  midi_byte_stream_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .channel      (channel),
    .first_data   (first_data),
    .second_data  (second_data),
    .song_pointer (song_pointer),
    .realtime_code(realtime_code)
  );

  // Tracks parser state, predicts events per byte and checks them in order.
  class midi_event_scoreboard;
    logic [7:0]  run_status;
    bit          await_second;
    logic [6:0]  held_first;
    bit          sysex_open;
    midi_event_t pending_events[$];
    int          errors;

    function new();
      run_status   = ST_NONE;
      await_second = 1'b0;
      held_first   = '0;
      sysex_open   = 1'b0;
      errors       = 0;
    endfunction

    function midi_event_t make_event(event_kind_t k, logic [3:0] ch, logic [6:0] d1,
                                     logic [6:0] d2, logic [13:0] spp, logic [7:0] rt);
      midi_event_t ev;
      ev.kind          = k;
      ev.channel       = ch;
      ev.first_data    = d1;
      ev.second_data   = d2;
      ev.song_pointer  = spp;
      ev.realtime_code = rt;
      return ev;
    endfunction

    // Advance the parser state by one byte; return 1 when an event comes out.
    function bit decode_byte(logic [7:0] b, output midi_event_t ev);
      logic [6:0] d;
      logic [3:0] ch;
      d  = b[6:0];
      ch = run_status[3:0];
      ev = '0;
      if (b[7]) begin
        // Real-time bytes pass through; system reset also drops running status.
        if (b >= ST_RT_MIN) begin
          if (b == ST_SYS_RESET) run_status = ST_NONE;
          ev = make_event(KIND_REALTIME, 4'd0, 7'd0, 7'd0, 14'd0, b);
          return 1'b1;
        end
        sysex_open   = 1'b0;
        await_second = 1'b0;
        if (b < ST_SYSEX_START) begin
          run_status = b;
          return 1'b0;
        end
        run_status = ST_NONE;
        case (b)
          ST_TUNE: begin
            ev = make_event(KIND_TUNE, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0);
            return 1'b1;
          end
          ST_SYSEX_START: begin
            sysex_open = 1'b1;
            ev = make_event(KIND_SYSEX_START, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0);
            return 1'b1;
          end
          ST_SYSEX_END: begin
            ev = make_event(KIND_SYSEX_STOP, 4'd0, 7'd0, 7'd0, 14'd0, 8'd0);
            return 1'b1;
          end
          ST_MTC, ST_SONG_POS, ST_SONG_SEL: run_status = b;
          default: ;
        endcase
        return 1'b0;
      end

      if (sysex_open) begin
        ev = make_event(KIND_SYSEX_DATA, 4'd0, d, 7'd0, 14'd0, 8'd0);
        return 1'b1;
      end

      // Complete a three-byte message.
      if (await_second) begin
        await_second = 1'b0;
        if (run_status == ST_SONG_POS) begin
          run_status = ST_NONE;
          ev = make_event(KIND_SONG_POS, 4'd0, held_first, d, {d, held_first}, 8'd0);
          return 1'b1;
        end
        case (run_status[7:4])
          HI_NOTE_ON:  ev = make_event((d == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON, ch,
                                       held_first, d, 14'd0, 8'd0);
          HI_NOTE_OFF: ev = make_event(KIND_NOTE_OFF, ch, held_first, d, 14'd0, 8'd0);
          HI_PITCH:    ev = make_event(KIND_PITCH, ch, held_first, d, 14'd0, 8'd0);
          HI_POLY_AT:  ev = make_event(KIND_POLY_AT, ch, held_first, d, 14'd0, 8'd0);
          HI_CC:       ev = make_event(KIND_CC, ch, held_first, d, 14'd0, 8'd0);
          default:     return 1'b0;
        endcase
        return 1'b1;
      end

      // First data byte under the running status.
      if (run_status == ST_NONE) return 1'b0;
      if (run_status == ST_MTC) begin
        run_status = ST_NONE;
        ev = make_event(KIND_MTC, 4'd0, d, 7'd0, 14'd0, 8'd0);
        return 1'b1;
      end
      if (run_status == ST_SONG_SEL) begin
        run_status = ST_NONE;
        ev = make_event(KIND_SONG_SEL, 4'd0, d, 7'd0, 14'd0, 8'd0);
        return 1'b1;
      end
      case (run_status[7:4])
        HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CC, HI_PITCH: begin
          held_first   = d;
          await_second = 1'b1;
          return 1'b0;
        end
        HI_PROGRAM: begin
          ev = make_event(KIND_PROGRAM, ch, d, 7'd0, 14'd0, 8'd0);
          return 1'b1;
        end
        HI_CHAN_AT: begin
          ev = make_event(KIND_CHAN_AT, ch, d, 7'd0, 14'd0, 8'd0);
          return 1'b1;
        end
        default: begin
          if (run_status == ST_SONG_POS) begin
            held_first   = d;
            await_second = 1'b1;
          end
          return 1'b0;
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      midi_event_t ev;
      if (decode_byte(b, ev)) pending_events.push_back(ev);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      end
    endfunction

    function void check_event(midi_event_t got);
      midi_event_t exp_ev;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: event with none expected, expected none, actual kind %0d", $time,
                 got.kind);
        return;
      end
      exp_ev = pending_events.pop_front();
      compare_field("event_kind", exp_ev.kind, got.kind);
      compare_field("channel", exp_ev.channel, got.channel);
      compare_field("first_data", exp_ev.first_data, got.first_data);
      compare_field("second_data", exp_ev.second_data, got.second_data);
      compare_field("song_pointer", exp_ev.song_pointer, got.song_pointer);
      compare_field("realtime_code", exp_ev.realtime_code, got.realtime_code);
    endfunction
  endclass

  midi_event_scoreboard sb = new();

  int         bytes_sent;
  int         burst_left;
  logic [7:0] last_voice_status;
  logic [7:0] directed_seq[$];

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Observe both handshakes.
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) sb.note_byte(rx_byte);
    if (!rst && event_valid && !event_stall)
      sb.check_event('{event_kind_t'(event_kind), channel, first_data, second_data,
                       song_pointer, realtime_code});
  end

  // Offer one byte, hold it until taken, then idle between bursts.
  task automatic send_byte(input logic [7:0] b);
    byte_valid <= 1'b1;
    rx_byte    <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return DATA_MAX;
      default: return {1'b0, 7'($urandom)};
    endcase
  endfunction

  // Build one message, mostly well formed, and send it with stray real-time bytes.
  task automatic send_random_message();
    logic [7:0] msg[$];
    logic [7:0] st;
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // Channel voice, with or without a repeated status byte.
      if (last_voice_status == ST_NONE || $urandom_range(0, 2) != 0) begin
        st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        msg.push_back(st);
        last_voice_status = st;
      end
      msg.push_back(rand_data());
      if (last_voice_status[7:4] != HI_PROGRAM && last_voice_status[7:4] != HI_CHAN_AT)
        msg.push_back(rand_data());
    end else if (pick < 70) begin
      // SysEx, sometimes left open for the next status to end it.
      msg.push_back(ST_SYSEX_START);
      n = $urandom_range(0, 6);
      repeat (n) msg.push_back(rand_data());
      if ($urandom_range(0, 4) != 0) msg.push_back(ST_SYSEX_END);
      last_voice_status = ST_NONE;
    end else if (pick < 82) begin
      // System common.
      case ($urandom_range(0, 5))
        0: begin msg.push_back(ST_MTC); msg.push_back(rand_data()); end
        1: begin
          msg.push_back(ST_SONG_POS);
          msg.push_back(rand_data());
          msg.push_back(rand_data());
        end
        2: begin msg.push_back(ST_SONG_SEL); msg.push_back(rand_data()); end
        3: msg.push_back(ST_TUNE);
        4: msg.push_back(ST_UNDEF_F4);
        default: msg.push_back(ST_UNDEF_F5);
      endcase
      last_voice_status = ST_NONE;
    end else if (pick < 88) begin
      msg.push_back(8'($urandom_range(ST_RT_MIN, ST_SYS_RESET)));
    end else begin
      // Noise: any byte at all.
      n = $urandom_range(1, 3);
      repeat (n) msg.push_back(8'($urandom));
    end
    foreach (msg[i]) begin
      if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(ST_RT_MIN, ST_SYS_RESET)));
      send_byte(msg[i]);
    end
  endtask

  // Receiver: one long hold-off early on, then stall patterns of its own.
  initial begin
    int mode;
    int len;
    event_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat (120) @(posedge clk);
    event_stall <= 1'b1;
    repeat (250) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 4);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        case (mode)
          0:       event_stall <= 1'b0;
          1:       event_stall <= 1'($urandom_range(0, 1));
          2:       event_stall <= ~event_stall;
          3:       event_stall <= ($urandom_range(0, 7) == 0);
          default: event_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Sender: directed bytes, then random messages, then drain and report.
  initial begin
    byte_valid        = 1'b0;
    rx_byte           = 8'h00;
    bytes_sent        = 0;
    burst_left        = 4;
    last_voice_status = ST_NONE;
    @(posedge clk);
    while (rst) @(posedge clk);

    directed_seq = '{
      8'h42,                                         // data with no status
      {HI_NOTE_ON, 4'hF}, 8'h00, DATA_MAX,           // note on, field extremes
      DATA_MAX, 8'h00,                               // running status, velocity zero
      ST_SYSEX_START, DATA_MAX, ST_ACTIVE_SENSE,     // sysex with real-time inside,
      {HI_POLY_AT, 4'hA}, 8'h11, 8'h22,              // ended by a channel status
      {HI_CC, 4'h3}, 8'h07,                          // pending byte dropped by status
      {HI_PITCH, 4'hC}, 8'h00, DATA_MAX,
      {HI_PROGRAM, 4'h0}, 8'h05,
      {HI_CHAN_AT, 4'h7}, 8'h40,
      {HI_NOTE_OFF, 4'h1}, 8'h3C, ST_SYS_RESET,      // system reset while pending
      8'h00, 8'h01,
      ST_MTC, 8'h55,
      ST_SONG_POS, DATA_MAX, DATA_MAX,
      ST_SONG_SEL, 8'h03,
      ST_TUNE, ST_UNDEF_F4, 8'h10,                   // undefined status clears status
      ST_SYSEX_END                                   // stray sysex end
    };
    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) send_random_message();

    // Drain: no more requests, wait for every expected event.
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- midi_byte_stream_parser.f -----
+incdir+hdl
hdl/mbp_pkg.sv
hdl/mbp_in_reg.sv
hdl/mbp_decode.sv
hdl/mbp_out_reg.sv
hdl/midi_byte_stream_parser.sv
dv/tb_midi_byte_stream_parser.sv
